// ===== src/twkb_pkg.sv =====
// ----------------------------------------------------------------------------
// twkb_pkg
// shared constants and result type of the linestring coordinate decoder
// ----------------------------------------------------------------------------
package twkb_pkg;

    localparam int COORD_BITS = 32;
    localparam int MAX_DIMS   = 4;
    localparam int DIM_W      = $clog2(MAX_DIMS);

    typedef struct packed {
        logic signed [31:0] coord_value;
        logic [1:0]         dim_index;
        logic [31:0]        point_index;
        logic signed [3:0]  decimal_exp;
        logic [2:0]         dims_in_use;
        logic               last;
    } coord_t;

    typedef struct packed {
        logic   valid;
        coord_t data;
    } coord_res_t;

endpackage

// ===== src/twkb_byte_if.sv =====
// ----------------------------------------------------------------------------
// twkb_byte_if
// byte stream channel into the decoder
// ----------------------------------------------------------------------------
interface twkb_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);

endinterface

// ===== src/twkb_coord_if.sv =====
// ----------------------------------------------------------------------------
// twkb_coord_if
// coordinate result channel out of the decoder
// ----------------------------------------------------------------------------
interface twkb_coord_if;

    logic               valid;
    logic               ready;
    logic signed [31:0] coord_value;
    logic [1:0]         dim_index;
    logic [31:0]        point_index;
    logic signed [3:0]  decimal_exp;
    logic [2:0]         dims_in_use;
    logic               last;

    modport source (
        output valid, output coord_value, output dim_index, output point_index,
        output decimal_exp, output dims_in_use, output last, input ready
    );
    modport sink (
        input valid, input coord_value, input dim_index, input point_index,
        input decimal_exp, input dims_in_use, input last, output ready
    );

endinterface

// ===== src/twkb_line_coordinate_decoder.sv =====
// ----------------------------------------------------------------------------
// twkb_line_coordinate_decoder
// byte-serial decoder of compact binary linestring records into coordinates
// ----------------------------------------------------------------------------
// path: the final varint byte of a coordinate is registered in the input stage,
//   and the parser result for it is then registered in the output stage
// throughput: one byte per cycle while the output stage is free; the input stage,
//   the varint collector and the per-dimension accumulate all act on each byte together
// reset: rst_n clears the input and output stages and all record state; the
//   next byte after reset is taken as a header
module twkb_line_coordinate_decoder (
    input  logic              clk,
    input  logic              rst_n,
    twkb_byte_if.sink         bytes,
    twkb_coord_if.source      coords
);
    import twkb_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       out_valid_reg, out_valid_next;
    coord_t     out_reg;
    coord_res_t res;
    logic       out_free;
    logic       proc_fire;
    logic       in_load;
    logic       out_load;

    assign out_free    = !out_valid_reg || coords.ready;
    assign proc_fire   = in_valid_reg && out_free;
    assign bytes.ready = !in_valid_reg || proc_fire;
    assign in_load     = bytes.valid && bytes.ready;
    assign out_load    = proc_fire && res.valid;

    twkb_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (proc_fire),
        .data_byte  (in_byte_reg),
        .first_byte (in_first_reg),
        .res        (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_load)
            in_valid_next = 1'b1;
        else if (proc_fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (coords.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_byte_reg  <= bytes.data_byte;
            in_first_reg <= bytes.first_byte;
        end
        if (out_load)
        begin
            out_reg <= res.data;
        end
    end

    assign coords.valid       = out_valid_reg;
    assign coords.coord_value = out_reg.coord_value;
    assign coords.dim_index   = out_reg.dim_index;
    assign coords.point_index = out_reg.point_index;
    assign coords.decimal_exp = out_reg.decimal_exp;
    assign coords.dims_in_use = out_reg.dims_in_use;
    assign coords.last        = out_reg.last;

`ifndef NO_ASSERTIONS
    a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || coords.ready))
        else $error("result register overwritten before transfer");

    a_input_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !proc_fire) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("pending input byte lost");

    a_output_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (coords.valid && coords.ready && !out_load) |=> !coords.valid)
        else $error("result repeated after transfer");
`endif

endmodule

// ===== src/twkb_varint.sv =====
// ----------------------------------------------------------------------------
// twkb_varint
// collects little-endian base-128 varints, wrapping at 32 bits
// ----------------------------------------------------------------------------
module twkb_varint (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clear,
    input  logic        feed,
    input  logic [7:0]  data_byte,
    output logic        done,
    output logic [31:0] value
);
    import twkb_pkg::*;

    logic [31:0] accum_reg;
    logic [31:0] accum_next;
    logic [5:0]  shift_reg;
    logic [5:0]  shift_next;
    logic [38:0] shifted;
    logic [31:0] contrib;

    assign shifted = {32'b0, data_byte[6:0]} << shift_reg;
    assign contrib = (shift_reg < 6'd32) ? shifted[31:0] : 32'b0;
    assign value   = accum_reg | contrib;
    assign done    = feed && !data_byte[7];

    always_comb
    begin
        accum_next = accum_reg;
        shift_next = shift_reg;
        if (clear || done)
        begin
            accum_next = 32'b0;
            shift_next = 6'b0;
        end
        else if (feed)
        begin
            accum_next = value;
            if (shift_reg < 6'd32)
            begin
                shift_next = shift_reg + 6'd7;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= 32'b0;
            shift_reg <= 6'b0;
        end
        else
        begin
            accum_reg <= accum_next;
            shift_reg <= shift_next;
        end
    end

endmodule

// ===== src/twkb_parser.sv =====
// ----------------------------------------------------------------------------
// twkb_parser
// header parsing, point counting and per-dimension delta accumulation
// ----------------------------------------------------------------------------
module twkb_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [7:0]           data_byte,
    input  logic                 first_byte,
    output twkb_pkg::coord_res_t res
);
    import twkb_pkg::*;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_META   = 3'd1;
    localparam logic [2:0] PH_EXT    = 3'd2;
    localparam logic [2:0] PH_SIZE   = 3'd3;
    localparam logic [2:0] PH_COUNT  = 3'd4;
    localparam logic [2:0] PH_COORD  = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    logic [2:0]            phase_reg, phase_next, phase_cur;
    logic [COORD_BITS-1:0] run_reg [MAX_DIMS];
    logic [COORD_BITS-1:0] run_sum;
    logic [2:0]            dims_reg, dims_next;
    logic                  size_reg, size_next;
    logic signed [3:0]     prec_xy_reg, prec_xy_next;
    logic [2:0]            prec_z_reg, prec_z_next;
    logic [2:0]            prec_m_reg, prec_m_next;
    logic                  has_z_reg, has_z_next;
    logic [31:0]           total_reg, total_next;
    logic [31:0]           point_reg, point_next;
    logic [DIM_W-1:0]      dim_reg, dim_next;
    logic                  run_we;
    logic [2:0]            ext_dims;
    logic                  vi_feed;
    logic                  vi_done;
    logic [31:0]           vi_value;
    logic [31:0]           delta;
    logic                  dim_wrap;
    logic                  fin;
    logic signed [3:0]     exp_sel;

    assign phase_cur = first_byte ? PH_HEADER : phase_reg;
    assign vi_feed   = fire && (phase_cur == PH_SIZE || phase_cur == PH_COUNT
                                || phase_cur == PH_COORD);

    twkb_varint u_varint (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (fire && first_byte),
        .feed      (vi_feed),
        .data_byte (data_byte),
        .done      (vi_done),
        .value     (vi_value)
    );

    // zigzag decode
    assign delta    = (vi_value >> 1) ^ {32{vi_value[0]}};
    assign run_sum  = run_reg[dim_reg] + COORD_BITS'(signed'(delta));
    assign dim_wrap = (3'(dim_reg) + 3'd1) >= dims_reg;
    assign fin      = (point_reg == total_reg - 32'd1) && dim_wrap;
    assign ext_dims = 3'd2 + {2'b0, data_byte[0]} + {2'b0, data_byte[1]};

    always_comb
    begin
        if (dim_reg < 2'(2))
            exp_sel = prec_xy_reg;
        else if (dim_reg == 2'(2) && has_z_reg)
            exp_sel = signed'({1'b0, prec_z_reg});
        else
            exp_sel = signed'({1'b0, prec_m_reg});
    end

    always_comb
    begin
        phase_next   = phase_reg;
        dims_next    = dims_reg;
        size_next    = size_reg;
        prec_xy_next = prec_xy_reg;
        prec_z_next  = prec_z_reg;
        prec_m_next  = prec_m_reg;
        has_z_next   = has_z_reg;
        total_next   = total_reg;
        point_next   = point_reg;
        dim_next     = dim_reg;
        run_we       = 1'b0;
        res.valid    = 1'b0;
        res.data.coord_value = 32'(signed'(run_sum));
        res.data.dim_index   = 2'(dim_reg);
        res.data.point_index = point_reg;
        res.data.decimal_exp = exp_sel;
        res.data.dims_in_use = dims_reg;
        res.data.last        = fin;

        if (fire && first_byte)
        begin
            dims_next    = 3'd2;
            size_next    = 1'b0;
            prec_xy_next = 4'sd0;
            prec_z_next  = 3'd0;
            prec_m_next  = 3'd0;
            has_z_next   = 1'b0;
            total_next   = 32'd0;
            point_next   = 32'd0;
            dim_next     = '0;
        end

        if (fire)
        begin
            unique case (phase_cur)
                PH_HEADER:
                begin
                    // zigzag of the upper nibble
                    prec_xy_next = data_byte[4] ? signed'(~{1'b0, data_byte[7:5]})
                                                : signed'({1'b0, data_byte[7:5]});
                    phase_next   = PH_META;
                end
                PH_META:
                begin
                    size_next = data_byte[1];
                    if (data_byte[3])
                        phase_next = PH_EXT;
                    else
                        phase_next = data_byte[1] ? PH_SIZE : PH_COUNT;
                end
                PH_EXT:
                begin
                    has_z_next  = data_byte[0];
                    prec_z_next = data_byte[0] ? data_byte[4:2] : 3'd0;
                    prec_m_next = data_byte[1] ? data_byte[7:5] : 3'd0;
                    dims_next   = (ext_dims > 3'(MAX_DIMS)) ? 3'(MAX_DIMS) : ext_dims;
                    phase_next  = size_reg ? PH_SIZE : PH_COUNT;
                end
                PH_SIZE:
                begin
                    if (vi_done)
                        phase_next = PH_COUNT;
                end
                PH_COUNT:
                begin
                    if (vi_done)
                    begin
                        total_next = vi_value;
                        point_next = 32'd0;
                        dim_next   = '0;
                        phase_next = (vi_value != 32'd0) ? PH_COORD : PH_DONE;
                    end
                end
                PH_COORD:
                begin
                    if (vi_done)
                    begin
                        run_we    = 1'b1;
                        res.valid = 1'b1;
                        if (fin)
                            phase_next = PH_DONE;
                        else if (dim_wrap)
                        begin
                            dim_next   = '0;
                            point_next = point_reg + 32'd1;
                        end
                        else
                            dim_next = dim_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            dims_reg    <= 3'd2;
            size_reg    <= 1'b0;
            prec_xy_reg <= 4'sd0;
            prec_z_reg  <= 3'd0;
            prec_m_reg  <= 3'd0;
            has_z_reg   <= 1'b0;
            total_reg   <= 32'd0;
            point_reg   <= 32'd0;
            dim_reg     <= '0;
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                run_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg   <= phase_next;
            dims_reg    <= dims_next;
            size_reg    <= size_next;
            prec_xy_reg <= prec_xy_next;
            prec_z_reg  <= prec_z_next;
            prec_m_reg  <= prec_m_next;
            has_z_reg   <= has_z_next;
            total_reg   <= total_next;
            point_reg   <= point_next;
            dim_reg     <= dim_next;
            if (fire && first_byte)
            begin
                for (int i = 0; i < MAX_DIMS; i++)
                begin
                    run_reg[i] <= '0;
                end
            end
            else if (run_we)
            begin
                run_reg[dim_reg] <= run_sum;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_res_only_in_coord: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (phase_reg == PH_COORD && !first_byte && fire))
        else $error("result outside coordinate phase");

    a_dims_range: assert property (@(posedge clk) disable iff (!rst_n)
        (dims_reg >= 3'd2 && dims_reg <= 3'(MAX_DIMS)))
        else $error("dimension count out of range");

    a_last_ends_record: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.data.last) |=> (phase_reg == PH_DONE))
        else $error("record not closed after last coordinate");

    a_dim_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_COORD) |-> (3'(dim_reg) < dims_reg))
        else $error("dimension counter beyond dimension count");
`endif

endmodule
